@@ rtl/bmtg_pkg.sv @@
// Package for the bitmap text glyph plotter.
// Holds shared constants, the register block struct and the engine state type.
// No dependencies.
package bmtg_pkg;

   localparam int GLYPH_COUNT_DEF = 96;
   localparam int PIXEL_ADDR_W    = 16;
   localparam int CSR_INDEX_W     = 2;
   localparam int CSR_DATA_W      = 16;

   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_DRAW  = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_PITCH   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLOR   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHAR_DX = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LINE_DY = 2'd3;

   localparam logic [7:0] CHAR_NULL    = 8'd0;
   localparam logic [7:0] CHAR_NEWLINE = 8'd10;
   localparam logic [7:0] CHAR_FIRST   = 8'd32;

   localparam logic [10:0] PITCH_RST   = 11'd240;
   localparam logic [15:0] COLOR_RST   = 16'd32767;
   localparam logic [4:0]  CHAR_DX_RST = 5'd8;
   localparam logic [4:0]  LINE_DY_RST = 5'd8;

   typedef struct packed {
      logic [10:0] pitch;
      logic [15:0] color;
      logic [4:0]  char_dx;
      logic [4:0]  line_dy;
   } cfg_type;

   typedef enum logic [1:0] {
      ENG_IDLE,
      ENG_FETCH,
      ENG_EMIT
   } eng_state_type;

endpackage

@@ rtl/bmtg_if.sv @@
// Channel interfaces of the bitmap text glyph plotter: request, response, csr write.
// Depends on bmtg_pkg.
interface bmtg_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [7:0]  char_code;
   logic [9:0]  font_index;
   logic [7:0]  font_bits;
   logic [15:0] start_address;

   modport source (output valid, operation, char_code, font_index, font_bits,
                   start_address, input ready);
   modport sink (input valid, operation, char_code, font_index, font_bits,
                 start_address, output ready);
endinterface

interface bmtg_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [bmtg_pkg::PIXEL_ADDR_W-1:0] pixel_address;
   logic [15:0]                       pixel_color;
   logic                              last;

   modport source (output valid, pixel_address, pixel_color, last, input ready);
   modport sink (input valid, pixel_address, pixel_color, last, output ready);
endinterface

interface bmtg_csr_if;
   logic                             valid;
   logic                             ready;
   logic [bmtg_pkg::CSR_INDEX_W-1:0] index;
   logic [bmtg_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/bmtg_engine.sv @@
// Glyph engine: font memory, cursor state and the row/bit walk producing pixel writes.
// Depends on bmtg_pkg and bmtg_if.
module bmtg_engine #(
   parameter int GLYPH_COUNT = bmtg_pkg::GLYPH_COUNT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  bmtg_pkg::cfg_type cfg,
   bmtg_req_if.sink          req_chan,
   bmtg_rsp_if.source        rsp_chan
);

   localparam int FontBytes    = GLYPH_COUNT * 8;
   localparam int FontAddrBits = $clog2(FontBytes);
   localparam int AW           = bmtg_pkg::PIXEL_ADDR_W;
   localparam logic [11:0] FontBytesW  = 12'(FontBytes);
   localparam logic [8:0]  GlyphCountW = 9'(GLYPH_COUNT);

   logic [7:0] font_mem [FontBytes];
   logic [7:0] rd_data_ff;

   bmtg_pkg::eng_state_type state_ff, state_in;

   logic [AW-1:0]           line_base_ff, line_base_in;
   logic [AW-1:0]           column_ff, column_in;
   logic [FontAddrBits-1:0] font_base_ff, font_base_in;
   logic [AW-1:0]           row_base_ff, row_base_in;
   logic [2:0]              row_ff, row_in;
   logic [7:0]              bits_ff, bits_in;
   logic                    pend_valid_ff, pend_valid_in;
   logic [AW-1:0]           pend_addr_ff, pend_addr_in;
   logic                    out_valid_ff, out_valid_in;
   logic [AW-1:0]           out_addr_ff, out_addr_in;
   logic [15:0]             out_color_ff, out_color_in;
   logic                    out_last_ff, out_last_in;

   logic                    accept;
   logic                    slot_free;
   logic                    bits_nz;
   logic                    row_end;
   logic                    need_push;
   logic                    stall;
   logic                    push;
   logic                    wr_en;
   logic                    rd_en;
   logic [FontAddrBits-1:0] rd_addr;
   logic [AW-1:0]           nl_step;
   logic [7:0]              glyph_off;
   logic [7:0]              glyph;
   logic [FontAddrBits-1:0] glyph_base;
   logic                    draw_char;

   function automatic logic [2:0] low_bit(input logic [7:0] v);
      logic [2:0] pos;
      pos = 3'd0;
      for (int i = 7; i >= 0; i--) begin
         if (v[i]) begin
            pos = 3'(i);
         end
      end
      return pos;
   endfunction

   assign accept    = req_chan.valid && req_chan.ready;
   assign slot_free = !out_valid_ff || rsp_chan.ready;
   assign bits_nz   = bits_ff != 8'd0;
   assign row_end   = !bits_nz && (row_ff == 3'd7);
   assign need_push = (state_ff == bmtg_pkg::ENG_EMIT) && pend_valid_ff && (bits_nz || row_end);
   assign stall     = need_push && !slot_free;
   assign push      = need_push && slot_free;
   assign nl_step   = AW'(cfg.pitch) * AW'(cfg.line_dy);
   assign glyph_off = req_chan.char_code - bmtg_pkg::CHAR_FIRST;
   assign glyph     = (req_chan.char_code >= bmtg_pkg::CHAR_FIRST
                       && {1'b0, glyph_off} < GlyphCountW) ? glyph_off : 8'd0;
   assign glyph_base = FontAddrBits'({glyph, 3'b000});
   assign draw_char  = (req_chan.operation == bmtg_pkg::OP_DRAW)
                       && (req_chan.char_code != bmtg_pkg::CHAR_NULL)
                       && (req_chan.char_code != bmtg_pkg::CHAR_NEWLINE);

   assign req_chan.ready         = state_ff == bmtg_pkg::ENG_IDLE;
   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.pixel_address = out_addr_ff;
   assign rsp_chan.pixel_color   = out_color_ff;
   assign rsp_chan.last          = out_last_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bmtg_pkg::ENG_IDLE: begin
            if (accept && draw_char) begin
               state_in = bmtg_pkg::ENG_FETCH;
            end
         end
         bmtg_pkg::ENG_FETCH: begin
            state_in = bmtg_pkg::ENG_EMIT;
         end
         bmtg_pkg::ENG_EMIT: begin
            if (row_end && !stall) begin
               state_in = bmtg_pkg::ENG_IDLE;
            end
         end
         default: begin
            state_in = bmtg_pkg::ENG_IDLE;
         end
      endcase
   end

   always_comb begin
      line_base_in  = line_base_ff;
      column_in     = column_ff;
      font_base_in  = font_base_ff;
      row_base_in   = row_base_ff;
      row_in        = row_ff;
      bits_in       = bits_ff;
      pend_valid_in = pend_valid_ff;
      pend_addr_in  = pend_addr_ff;
      wr_en         = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = font_base_ff;
      unique case (state_ff)
         bmtg_pkg::ENG_IDLE: begin
            if (accept) begin
               case (req_chan.operation)
                  bmtg_pkg::OP_LOAD: begin
                     wr_en = {2'b00, req_chan.font_index} < FontBytesW;
                  end
                  bmtg_pkg::OP_START: begin
                     line_base_in = req_chan.start_address;
                     column_in    = '0;
                  end
                  bmtg_pkg::OP_DRAW: begin
                     if (req_chan.char_code == bmtg_pkg::CHAR_NEWLINE) begin
                        line_base_in = line_base_ff + nl_step;
                        column_in    = '0;
                     end else if (draw_char) begin
                        font_base_in = glyph_base;
                        rd_en        = 1'b1;
                        rd_addr      = glyph_base;
                        row_base_in  = line_base_ff + column_ff;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         bmtg_pkg::ENG_FETCH: begin
            bits_in = rd_data_ff;
            row_in  = 3'd0;
            rd_en   = 1'b1;
            rd_addr = font_base_ff + FontAddrBits'(3'd1);
         end
         bmtg_pkg::ENG_EMIT: begin
            if (!stall) begin
               if (bits_nz) begin
                  pend_valid_in = 1'b1;
                  pend_addr_in  = row_base_ff + AW'(low_bit(bits_ff));
                  bits_in       = bits_ff & (bits_ff - 8'd1);
               end else if (row_end) begin
                  pend_valid_in = 1'b0;
                  column_in     = column_ff + AW'(cfg.char_dx);
               end else begin
                  bits_in     = rd_data_ff;
                  row_in      = row_ff + 3'd1;
                  row_base_in = row_base_ff + AW'(cfg.pitch);
                  if (row_ff < 3'd6) begin
                     rd_en   = 1'b1;
                     rd_addr = font_base_ff + FontAddrBits'(3'(row_ff + 3'd2));
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      out_addr_in  = out_addr_ff;
      out_color_in = out_color_ff;
      out_last_in  = out_last_ff;
      if (push) begin
         out_valid_in = 1'b1;
         out_addr_in  = pend_addr_ff;
         out_color_in = cfg.color;
         out_last_in  = row_end;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         font_mem[FontAddrBits'(req_chan.font_index)] <= req_chan.font_bits;
      end
      if (rd_en) begin
         rd_data_ff <= font_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= bmtg_pkg::ENG_IDLE;
         line_base_ff  <= '0;
         column_ff     <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         line_base_ff  <= line_base_in;
         column_ff     <= column_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      font_base_ff <= font_base_in;
      row_base_ff  <= row_base_in;
      row_ff       <= row_in;
      bits_ff      <= bits_in;
      pend_addr_ff <= pend_addr_in;
      out_addr_ff  <= out_addr_in;
      out_color_ff <= out_color_in;
      out_last_ff  <= out_last_in;
   end

endmodule

@@ rtl/bitmap_text_glyph_plotter_core.sv @@
// Top level of the bitmap text glyph plotter: csr register block and glyph engine.
// Depends on bmtg_pkg, bmtg_if and bmtg_engine.
//
// Requests on req_chan: load one font row byte, start a string at a frame-buffer
// address, or draw a character. Each set pixel of a drawn glyph comes out on
// rsp_chan as one write (address, color), with last set on the final write of
// the character. Glyphs with no set pixels, newlines, code zero, loads and
// starts give no writes.
// Load, start and newline are handled in the idle state as they are taken. A draw
// first fetches the first font row from the font memory, then walks the glyph row
// by row, a step per pixel write and per row change, and halts when a write cannot
// enter the output register; the single read port of the font memory and the
// one-write-per-cycle output register set this pace. Each write passes the pending
// register, then the output register; the final one enters it as the walk ends.
// A new request is taken once the previous character is walked, while its
// final write may still wait in the output register.
// csr_chan writes pitch, color, char_dx and line_dy and is always ready. The user
// writes it only while no draw is in progress; the block does not enforce this.
// Reset clears line base, column, the registers to their defaults and all
// pending writes; the font memory keeps no reset value and must be loaded.
// When the receiver stalls, the walk halts with one write in the output
// register and the next one held pending.
module bitmap_text_glyph_plotter_core #(
   parameter int GLYPH_COUNT = bmtg_pkg::GLYPH_COUNT_DEF
) (
   input  logic       clock,
   input  logic       reset,
   bmtg_req_if.sink   req_chan,
   bmtg_rsp_if.source rsp_chan,
   bmtg_csr_if.sink   csr_chan
);

   bmtg_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            bmtg_pkg::CSR_PITCH:   cfg_in.pitch   = csr_chan.data[10:0];
            bmtg_pkg::CSR_COLOR:   cfg_in.color   = csr_chan.data;
            bmtg_pkg::CSR_CHAR_DX: cfg_in.char_dx = csr_chan.data[4:0];
            bmtg_pkg::CSR_LINE_DY: cfg_in.line_dy = csr_chan.data[4:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pitch   <= bmtg_pkg::PITCH_RST;
         cfg_ff.color   <= bmtg_pkg::COLOR_RST;
         cfg_ff.char_dx <= bmtg_pkg::CHAR_DX_RST;
         cfg_ff.line_dy <= bmtg_pkg::LINE_DY_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bmtg_engine #(
      .GLYPH_COUNT(GLYPH_COUNT)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for bitmap_text_glyph_plotter_core: font loads, starts and draws
// with random gaps and stalls, pixel writes checked against an in-bench predictor.
// Depends on bmtg_pkg, bmtg_if and the core RTL.
module tb;

   localparam int FONT_BYTES      = bmtg_pkg::GLYPH_COUNT_DEF * 8;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int QUIET_LIMIT     = 5000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int SETTLE_CYCLES   = 40;
   localparam int DRAIN_CYCLES    = 80;
   localparam int RANDOM_ITEMS    = 140;

   typedef struct {
      logic [1:0]  op;
      logic [7:0]  code;
      logic [9:0]  font_index;
      logic [7:0]  font_bits;
      logic [15:0] start_address;
   } glyph_request_type;

   typedef struct {
      logic [15:0] address;
      logic [15:0] color;
      logic        last;
   } pixel_write_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bmtg_req_if req_chan ();
   bmtg_rsp_if rsp_chan ();
   bmtg_csr_if csr_chan ();

   bitmap_text_glyph_plotter_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predicted state
   logic [7:0]  font_mem [FONT_BYTES];
   bit          font_loaded [FONT_BYTES];
   logic [15:0] line_base;
   logic [15:0] column;
   logic [10:0] pitch;
   logic [15:0] color;
   logic [4:0]  char_dx;
   logic [4:0]  line_dy;

   pixel_write_type expected_writes [$];
   int  mismatches;
   bit  gaps_on;
   bit  stalls_on;
   int  hold_off_asked;
   int  quiet_cycles;

   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int glyph_slot(logic [7:0] code);
      if (code >= bmtg_pkg::CHAR_FIRST
          && code < bmtg_pkg::CHAR_FIRST + bmtg_pkg::GLYPH_COUNT_DEF)
         return int'(code - bmtg_pkg::CHAR_FIRST);
      return 0;
   endfunction

   function automatic bit glyph_ready(int g);
      for (int r = 0; r < 8; r++)
         if (!font_loaded[g * 8 + r]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic logic [7:0] pick_draw_code();
      logic [7:0] c;
      if ($urandom_range(0, 3) == 0) begin
         do c = 8'($urandom);
         while (c == bmtg_pkg::CHAR_NULL || c == bmtg_pkg::CHAR_NEWLINE ||
                (c >= bmtg_pkg::CHAR_FIRST
                 && c < bmtg_pkg::CHAR_FIRST + bmtg_pkg::GLYPH_COUNT_DEF));
         return c;
      end
      for (int tries = 0; tries < 20; tries++) begin
         c = 8'(bmtg_pkg::CHAR_FIRST + $urandom_range(0, bmtg_pkg::GLYPH_COUNT_DEF - 1));
         if (glyph_ready(glyph_slot(c))) return c;
      end
      return bmtg_pkg::CHAR_FIRST;
   endfunction

   function automatic glyph_request_type random_request();
      glyph_request_type rq;
      rq.op            = 2'($urandom);
      rq.code          = 8'($urandom);
      rq.font_index    = 10'($urandom);
      rq.font_bits     = 8'($urandom);
      rq.start_address = 16'($urandom);
      return rq;
   endfunction

   // advance predicted state by one accepted request, queue its pixel writes
   task automatic plot_request(glyph_request_type rq);
      pixel_write_type char_writes [$];
      pixel_write_type w;
      logic [31:0]  sum;
      logic [7:0]   row_bits;
      int           g;
      case (rq.op)
         bmtg_pkg::OP_LOAD: begin
            if (rq.font_index < FONT_BYTES) begin
               font_mem[rq.font_index]    = rq.font_bits;
               font_loaded[rq.font_index] = 1'b1;
            end
         end
         bmtg_pkg::OP_START: begin
            line_base = rq.start_address;
            column    = '0;
         end
         bmtg_pkg::OP_DRAW: begin
            if (rq.code == bmtg_pkg::CHAR_NEWLINE) begin
               sum       = line_base + pitch * line_dy;
               line_base = sum[15:0];
               column    = '0;
            end else if (rq.code != bmtg_pkg::CHAR_NULL) begin
               g = glyph_slot(rq.code);
               for (int unsigned row = 0; row < 8; row++) begin
                  row_bits = font_mem[g * 8 + row];
                  for (int unsigned b = 0; b < 8; b++) begin
                     if (row_bits[b]) begin
                        sum       = line_base + row * pitch + column + b;
                        w.address = sum[15:0];
                        w.color   = color;
                        w.last    = 1'b0;
                        char_writes.push_back(w);
                     end
                  end
               end
               if (char_writes.size() > 0)
                  char_writes[char_writes.size() - 1].last = 1'b1;
               foreach (char_writes[i]) expected_writes.push_back(char_writes[i]);
               column = 16'(column + char_dx);
            end
         end
         default: ;
      endcase
   endtask

   task automatic send_request(glyph_request_type rq);
      int gap;
      gap = gaps_on ? idle_length() : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.operation     <= rq.op;
      req_chan.char_code     <= rq.code;
      req_chan.font_index    <= rq.font_index;
      req_chan.font_bits     <= rq.font_bits;
      req_chan.start_address <= rq.start_address;
      do @(posedge clock); while (!req_chan.ready);
      plot_request(rq);
   endtask

   task automatic send_draw(logic [7:0] code);
      glyph_request_type rq;
      rq      = random_request();
      rq.op   = bmtg_pkg::OP_DRAW;
      rq.code = code;
      send_request(rq);
   endtask

   task automatic send_start(logic [15:0] addr);
      glyph_request_type rq;
      rq               = random_request();
      rq.op            = bmtg_pkg::OP_START;
      rq.start_address = addr;
      send_request(rq);
   endtask

   task automatic send_load(logic [9:0] idx, logic [7:0] bits);
      glyph_request_type rq;
      rq            = random_request();
      rq.op         = bmtg_pkg::OP_LOAD;
      rq.font_index = idx;
      rq.font_bits  = bits;
      send_request(rq);
   endtask

   task automatic write_csr(logic [bmtg_pkg::CSR_INDEX_W-1:0] idx,
                            logic [bmtg_pkg::CSR_DATA_W-1:0] data);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= data;
      do @(posedge clock); while (!csr_chan.ready);
      case (idx)
         bmtg_pkg::CSR_PITCH:   pitch   = data[10:0];
         bmtg_pkg::CSR_COLOR:   color   = data;
         bmtg_pkg::CSR_CHAR_DX: char_dx = data[4:0];
         bmtg_pkg::CSR_LINE_DY: line_dy = data[4:0];
         default: ;
      endcase
   endtask

   // unused upper data bits are randomized
   task automatic config_set(logic [10:0] p, logic [15:0] c, logic [4:0] dx, logic [4:0] dy);
      write_csr(bmtg_pkg::CSR_PITCH, {5'($urandom), p});
      write_csr(bmtg_pkg::CSR_COLOR, c);
      write_csr(bmtg_pkg::CSR_CHAR_DX, {11'($urandom), dx});
      write_csr(bmtg_pkg::CSR_LINE_DY, {11'($urandom), dy});
      csr_chan.valid <= 1'b0;
   endtask

   // block idle: no request pending, all writes out, walk of an empty glyph finished
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      while (expected_writes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic test_font_setup();
      logic [7:0] pattern [8];
      pattern = '{8'h01, 8'h80, 8'h3C, 8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h18};
      for (int r = 0; r < 8; r++) begin
         send_load(10'(r), pattern[r]);
         send_load(10'(8 + r), 8'h00);
         send_load(10'(95 * 8 + r), 8'hFF);
         send_load(10'(33 * 8 + r), 8'($urandom));
      end
   endtask

   task automatic test_special_codes();
      glyph_request_type rq;
      send_start(16'h0000);
      send_draw(8'd65);
      send_draw(8'd127);
      send_draw(8'd33);
      send_draw(bmtg_pkg::CHAR_NULL);
      send_draw(bmtg_pkg::CHAR_FIRST);
      send_draw(bmtg_pkg::CHAR_NEWLINE);
      send_draw(8'd200);
      send_draw(8'd255);
      send_draw(8'd31);
      send_draw(8'd128);
      rq    = random_request();
      rq.op = OP_UNUSED;
      send_request(rq);
      send_load(10'd1023, 8'hFF);
      send_load(10'(FONT_BYTES), 8'hFF);
      send_draw(8'd127);
      send_start(16'hFFFF);
      send_draw(8'd127);
      send_start(16'hFFF0);
      send_draw(bmtg_pkg::CHAR_NEWLINE);
      send_draw(bmtg_pkg::CHAR_FIRST);
   endtask

   task automatic test_register_sweep();
      logic [10:0] pitches [5];
      logic [4:0]  steps [5];
      pitches = '{11'd0, 11'd2047, 11'd1, 11'd1024, 11'($urandom)};
      steps   = '{5'd0, 5'd31, 5'd1, 5'd16, 5'($urandom)};
      for (int s = 0; s < 5; s++) begin
         wait_idle();
         config_set(pitches[s], (s == 0) ? 16'h0000 : (s == 1) ? 16'hFFFF : 16'($urandom),
                    steps[s], (s == 4) ? 5'($urandom) : steps[s]);
         send_start(16'($urandom));
         for (int i = 0; i < 8; i++)
            send_draw((i % 4 == 3) ? bmtg_pkg::CHAR_NEWLINE : pick_draw_code());
      end
   endtask

   // receiver holds off while full glyphs keep coming, so the core must stall its input
   task automatic test_backpressure();
      gaps_on = 1'b0;
      hold_off_asked++;
      for (int i = 0; i < 6; i++) send_draw(8'd127);
      gaps_on = 1'b1;
   endtask

   task automatic test_random_text();
      glyph_request_type rq;
      int counted;
      int next_reconfig;
      int r;
      int g;
      counted       = 0;
      next_reconfig = 65;
      while (counted < RANDOM_ITEMS) begin
         if (counted >= next_reconfig) begin
            wait_idle();
            config_set(11'($urandom), 16'($urandom), 5'($urandom), 5'($urandom));
            next_reconfig += 65;
         end
         gaps_on   = !(counted >= 60 && counted < 110);
         stalls_on = gaps_on;
         r = $urandom_range(0, 99);
         if (r < 50) begin
            send_draw(pick_draw_code());
            counted++;
         end else if (r < 57) begin
            send_draw(bmtg_pkg::CHAR_NEWLINE);
            counted++;
         end else if (r < 64) begin
            send_start(16'($urandom));
            counted++;
         end else if (r < 80) begin
            g = $urandom_range(0, bmtg_pkg::GLYPH_COUNT_DEF - 1);
            for (int row = 0; row < 8; row++)
               send_load(10'(g * 8 + row), ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom));
            counted += 8;
         end else if (r < 84) begin
            send_draw(bmtg_pkg::CHAR_NULL);
         end else if (r < 88) begin
            rq    = random_request();
            rq.op = OP_UNUSED;
            send_request(rq);
         end else if (r < 91) begin
            send_load(10'($urandom_range(FONT_BYTES, 1023)), 8'($urandom));
         end else begin
            send_load(10'($urandom_range(0, FONT_BYTES - 1)), 8'($urandom));
            counted++;
         end
      end
      gaps_on   = 1'b1;
      stalls_on = 1'b1;
   endtask

   // response ready with random stalls and one long hold-off on request
   initial begin : rsp_ready_drive
      int stall;
      int hold_off_done;
      hold_off_done = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_asked != hold_off_done) begin
            hold_off_done = hold_off_asked;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else if (stalls_on && $urandom_range(0, 99) < 30) begin
            stall = idle_length();
            rsp_chan.ready <= (stall == 0);
            repeat (stall) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : pixel_checker
      pixel_write_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_writes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected pixel write: addr %h color %h last %b",
                        rsp_chan.pixel_address, rsp_chan.pixel_color, rsp_chan.last);
         end else begin
            want = expected_writes.pop_front();
            if (rsp_chan.pixel_address !== want.address || rsp_chan.pixel_color !== want.color
                || rsp_chan.last !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"pixel write mismatch: expected addr %h color %h last %b,",
                            " got addr %h color %h last %b"},
                           want.address, want.color, want.last, rsp_chan.pixel_address,
                           rsp_chan.pixel_color, rsp_chan.last);
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || (csr_chan.valid && csr_chan.ready))
         quiet_cycles <= 0;
      else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      gaps_on          = 1'b1;
      stalls_on        = 1'b1;
      line_base        = '0;
      column           = '0;
      pitch            = bmtg_pkg::PITCH_RST;
      color            = bmtg_pkg::COLOR_RST;
      char_dx          = bmtg_pkg::CHAR_DX_RST;
      line_dy          = bmtg_pkg::LINE_DY_RST;
      for (int i = 0; i < FONT_BYTES; i++) begin
         font_mem[i]    = 8'h00;
         font_loaded[i] = 1'b0;
      end
      req_chan.valid         <= 1'b0;
      req_chan.operation     <= bmtg_pkg::OP_LOAD;
      req_chan.char_code     <= '0;
      req_chan.font_index    <= '0;
      req_chan.font_bits     <= '0;
      req_chan.start_address <= '0;
      csr_chan.valid         <= 1'b0;
      csr_chan.index         <= bmtg_pkg::CSR_PITCH;
      csr_chan.data          <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_font_setup();
      test_special_codes();
      test_register_sweep();
      test_backpressure();
      test_random_text();

      req_chan.valid <= 1'b0;
      while (expected_writes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_writes.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/bmtg_pkg.sv
rtl/bmtg_if.sv
rtl/bmtg_engine.sv
rtl/bitmap_text_glyph_plotter_core.sv
sim/tb.sv
